/* rtl/core/bce_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types and constants for the cross-entropy loss and gradient block.
// ----------------------------------------------------------------------------
package bce_pkg;

	localparam int unsigned GRAD_W = 25;
	localparam int unsigned MEAN_W = 20;
	localparam int unsigned SUM_W  = 40;
	localparam int unsigned CNT_W  = 21;
	localparam int unsigned LOG_FRAC = 24;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [GRAD_W-2:0] GRAD_MAX = '1;
	localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

	// classified work item handed from front to back
	typedef struct packed {
		logic [24:0] x;
		logic        target;
		logic        last;
	} work_t;

endpackage
`default_nettype wire

/* rtl/core/bce_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bce_front
// Clamps the prediction, picks the operand for the selected label and
// holds the item in a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module bce_front #(
	parameter int unsigned PROB_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [15:0]     prediction,
	input  wire logic            target,
	input  wire logic            end_of_batch,
	output logic                 q_valid,
	input  wire logic            q_ready,
	output bce_pkg::work_t       q_item
);

	localparam logic [24:0] ONE = 25'(1) << PROB_BITS;

	logic [24:0] p_w;
	bce_pkg::work_t item_w;
	bce_pkg::work_t ent_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push, pop;

	// clamp into 1 .. ONE-1
	always_comb begin
		p_w = 25'(prediction);
		if (p_w == '0) p_w = 25'd1;
		if (p_w >= ONE) p_w = ONE - 25'd1;
		item_w.x = target ? p_w : (ONE - p_w);
		item_w.target = target;
		item_w.last = end_of_batch;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[rd_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= item_w;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("bad queue count");
`endif

endmodule
`default_nettype wire

/* rtl/core/bce_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bce_back
// Sequencer that runs one item at a time: restoring divide for the gradient,
// squaring log2 for the loss, then the batch mean divide on a last item.
// ----------------------------------------------------------------------------
module bce_back #(
	parameter int unsigned MAX_SAMPLES = 1048576,
	parameter int unsigned PROB_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	output logic                q_ready,
	input  wire bce_pkg::work_t q_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [24:0]         gradient,
	output logic [19:0]         mean_loss,
	output logic                loss_valid
);

	localparam int unsigned NUM_SH = PROB_BITS + 8;
	localparam logic [20:0] CNT_CAP = (MAX_SAMPLES > 2097151) ? 21'h1FFFFF : 21'(MAX_SAMPLES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GDIV = 3'd1;
	localparam logic [2:0] ST_LOG  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_MDIV = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]  state_q;
	logic [5:0]  step_q;
	bce_pkg::work_t item_q;
	logic [24:0] drem_q;
	logic [32:0] dquo_q;
	logic [5:0]  exp_q;
	logic [32:0] man_q;
	logic [23:0] frac_q;
	logic [63:0] prod_q;
	logic [39:0] sum_q;
	logic [20:0] cnt_q;
	logic [40:0] mrem_q;
	logic [39:0] mquo_q;
	logic [24:0] grad_q;
	logic [19:0] mean_q;
	logic        lv_q;
	logic        ov_q;

	logic [25:0] dtrial;
	logic [65:0] sq;
	logic [31:0] sqs;
	logic [29:0] dval;
	logic [40:0] lsum;
	logic [41:0] mtrial;
	logic [23:0] mag;
	logic [5:0]  lead_pos;

	assign q_ready = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign gradient = grad_q;
	assign mean_loss = mean_q;
	assign loss_valid = lv_q;

	// one bit per cycle of numerator 2^NUM_SH / x
	assign dtrial = {drem_q, (step_q == 6'(NUM_SH)) ? 1'b1 : 1'b0};
	assign sq = 66'(man_q) * 66'(man_q);
	assign sqs = 32'(sq >> 31);
	assign dval = 30'(PROB_BITS << bce_pkg::LOG_FRAC) - {exp_q, frac_q};
	assign lsum = 41'(sum_q) + 41'(prod_q[63:40]) + 41'(prod_q[39]);
	assign mtrial = {mrem_q, mquo_q[39]};
	assign mag = (dquo_q > 33'(bce_pkg::GRAD_MAX)) ? 24'(bce_pkg::GRAD_MAX) : 24'(dquo_q);

	// leading one position of the log operand
	always_comb begin
		lead_pos = '0;
		for (int i = 0; i < 25; i++) begin
			if (item_q.x[i]) lead_pos = 6'(i);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			// load a new result or drop the one just taken
			if (state_q == ST_OUT && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) state_q <= ST_GDIV;
				end
				ST_GDIV: begin
					if (step_q == 6'd0) state_q <= ST_LOG;
				end
				ST_LOG: begin
					if (step_q == 6'd0) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: state_q <= item_q.last ? ST_MDIV : ST_OUT;
				ST_MDIV: begin
					if (step_q == 6'd0) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ov_q || out_ready) begin
						state_q <= ST_IDLE;
						if (item_q.last) begin
							sum_q <= '0;
							cnt_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_ACC) begin
				sum_q <= lsum[40] ? '1 : lsum[39:0];
				if (cnt_q < CNT_CAP) cnt_q <= cnt_q + 21'd1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= q_item;
				drem_q <= '0;
				dquo_q <= '0;
				step_q <= 6'(NUM_SH);
			end
			ST_GDIV: begin
				if (dtrial >= 26'(item_q.x)) begin
					drem_q <= 25'(dtrial - 26'(item_q.x));
					dquo_q <= {dquo_q[31:0], 1'b1};
				end else begin
					drem_q <= dtrial[24:0];
					dquo_q <= {dquo_q[31:0], 1'b0};
				end
				if (step_q == 6'd0) begin
					// leading one of x, normalize to Q1.31
					exp_q <= lead_pos;
					man_q <= 33'(item_q.x) << (6'd31 - lead_pos);
					frac_q <= '0;
					step_q <= 6'(bce_pkg::LOG_FRAC - 1);
				end else begin
					step_q <= step_q - 6'd1;
				end
			end
			ST_LOG: begin
				if (sq[65:63] != 3'd0) begin
					man_q <= 33'(sq >> 32);
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					man_q <= 33'(sqs);
					frac_q <= {frac_q[22:0], 1'b0};
				end
				if (step_q != 6'd0) step_q <= step_q - 6'd1;
			end
			ST_MUL: prod_q <= 64'(dval) * 64'(bce_pkg::LN2_Q32);
			ST_ACC: begin
				mrem_q <= '0;
				mquo_q <= lsum[40] ? '1 : lsum[39:0];
				step_q <= 6'd39;
			end
			ST_MDIV: begin
				if (mtrial >= 42'(cnt_q)) begin
					mrem_q <= 41'(mtrial - 42'(cnt_q));
					mquo_q <= {mquo_q[38:0], 1'b1};
				end else begin
					mrem_q <= mtrial[40:0];
					mquo_q <= {mquo_q[38:0], 1'b0};
				end
				if (step_q != 6'd0) step_q <= step_q - 6'd1;
			end
			ST_OUT: begin
				if (!ov_q || out_ready) begin
					grad_q <= item_q.target ? 25'(-{1'b0, mag}) : {1'b0, mag};
					lv_q <= item_q.last;
					if (!item_q.last || cnt_q == '0) mean_q <= '0;
					else if (mquo_q[39:20] != '0) mean_q <= bce_pkg::MEAN_MAX;
					else mean_q <= mquo_q[19:0];
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> state_q == ST_IDLE) else $error("take outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> ov_q) else $error("result dropped");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_CAP) else $error("count above cap");
`endif

endmodule
`default_nettype wire

/* rtl/core/binary_cross_entropy_loss_grad.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// binary_cross_entropy_loss_grad
// Per-sample cross-entropy gradient with batch mean loss.
// ----------------------------------------------------------------------------
// One result per sample. A front queue of two entries takes samples while the
// back end works; the back end handles one sample at a time (a take step,
// one-bit gradient divide steps, squaring steps for the 24-bit log2 fraction,
// then multiply, accumulate and output), with the bit-serial mean divide
// before the output on a sample marked last.
// The output register holds a result until taken; the back end stalls in its
// output step while an earlier result still waits.
module binary_cross_entropy_loss_grad #(
	parameter int unsigned MAX_SAMPLES = 1048576,
	parameter int unsigned PROB_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] prediction
	input  wire logic        s_axis_tuser,   // target
	input  wire logic        s_axis_tlast,   // end_of_batch
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // [24:0] gradient, [44:25] mean_loss
	output logic             m_axis_tuser    // loss_valid
);

	logic q_valid, q_ready;
	bce_pkg::work_t q_item;
	logic [24:0] gradient;
	logic [19:0] mean_loss;

	bce_front #(.PROB_BITS(PROB_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.prediction(s_axis_tdata), .target(s_axis_tuser),
		.end_of_batch(s_axis_tlast),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	bce_back #(.MAX_SAMPLES(MAX_SAMPLES), .PROB_BITS(PROB_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.gradient(gradient), .mean_loss(mean_loss), .loss_valid(m_axis_tuser)
	);

	assign m_axis_tdata = {3'b000, mean_loss, gradient};

endmodule
`default_nettype wire

/* test/binary_cross_entropy_loss_grad_tb.sv */
// ----------------------------------------------------------------------------
// binary_cross_entropy_loss_grad_tb
// Streams labeled probabilities into the loss block and checks every gradient
// and every batch mean against an in-bench predictor of the same arithmetic.
// ----------------------------------------------------------------------------
module binary_cross_entropy_loss_grad_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SAMPLE_LIMIT = 1048576;
	localparam int unsigned FRAC_BITS = 16;

	typedef struct packed {
		logic [bce_pkg::GRAD_W-1:0] gradient;
		logic [bce_pkg::MEAN_W-1:0] mean_loss;
		logic                       loss_valid;
	} grad_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [15:0] prediction
	logic        s_axis_tuser;   // target
	logic        s_axis_tlast;   // end_of_batch
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // [24:0] gradient, [44:25] mean_loss
	logic        m_axis_tuser;   // loss_valid

	grad_result_t expected_q[$];
	logic [bce_pkg::SUM_W-1:0] batch_sum;
	logic [bce_pkg::CNT_W-1:0] batch_count;
	int mismatches;
	bit sink_idle_off;
	bit source_idle_off;

	binary_cross_entropy_loss_grad #(
		.MAX_SAMPLES(SAMPLE_LIMIT),
		.PROB_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// log2 in Q.24: integer part from the leading one, fraction by squaring
	function automatic logic [63:0] log2_fixed(input logic [63:0] x);
		logic [63:0] e;
		logic [63:0] m;
		logic [63:0] frac;
		e = 0;
		frac = 0;
		while (e < 40 && (x >> (e + 1)) != 0)
			e++;
		m = (x << (31 - e)) & 64'hFFFF_FFFF;
		for (int i = 0; i < bce_pkg::LOG_FRAC; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac = frac | 64'd1;
				m = m >> 1;
			end
		end
		return (e << bce_pkg::LOG_FRAC) | frac;
	endfunction

	// predict one sample's gradient and, on the batch end, the mean loss
	function automatic grad_result_t predict_gradient(input logic [15:0] pred,
			input logic label, input logic batch_end);
		logic [63:0] p;
		logic [63:0] x;
		logic [63:0] mag;
		logic [63:0] d;
		logic [63:0] loss;
		logic [63:0] total;
		logic [63:0] mean;
		grad_result_t r;
		p = 64'(pred);
		if (p == 0)
			p = 1;
		x = label ? p : (64'd65536 - p);
		mag = (64'd1 << 24) / x;
		if (mag > 64'd16777215)
			mag = 64'd16777215;
		r.gradient = label ? bce_pkg::GRAD_W'(-mag) : bce_pkg::GRAD_W'(mag);
		d = (64'd16 << bce_pkg::LOG_FRAC) - log2_fixed(x);
		loss = (d * 64'(bce_pkg::LN2_Q32) + (64'd1 << 39)) >> 40;
		total = 64'(batch_sum) + loss;
		if (total > 64'hFF_FFFF_FFFF)
			total = 64'hFF_FFFF_FFFF;
		batch_sum = total[bce_pkg::SUM_W-1:0];
		if (batch_count < SAMPLE_LIMIT)
			batch_count++;
		r.mean_loss = '0;
		r.loss_valid = batch_end;
		if (batch_end) begin
			mean = (batch_count != 0) ? 64'(batch_sum) / 64'(batch_count) : 64'd0;
			if (mean > 64'(bce_pkg::MEAN_MAX))
				mean = 64'(bce_pkg::MEAN_MAX);
			r.mean_loss = mean[bce_pkg::MEAN_W-1:0];
			batch_sum = '0;
			batch_count = '0;
		end
		return r;
	endfunction

	// send one sample: hold it until the transfer, then maybe idle
	task automatic send_sample(input logic [15:0] pred, input logic label,
			input logic batch_end);
		s_axis_tdata <= pred;
		s_axis_tuser <= label;
		s_axis_tlast <= batch_end;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		expected_q.push_back(predict_gradient(pred, label, batch_end));
		@(negedge clk);
		if (!source_idle_off && $urandom_range(99) < 27) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
	endtask

	// extremes of probability for both labels, batch ends at once
	task automatic test_directed();
		send_sample(16'd0, 1'b0, 1'b0);
		send_sample(16'd0, 1'b1, 1'b0);
		send_sample(16'd1, 1'b1, 1'b0);
		send_sample(16'd1, 1'b0, 1'b0);
		send_sample(16'hFFFF, 1'b0, 1'b0);
		send_sample(16'hFFFF, 1'b1, 1'b0);
		send_sample(16'h8000, 1'b0, 1'b0);
		send_sample(16'h8000, 1'b1, 1'b1);
		// batch of one sample, then worst-case losses
		send_sample(16'd1, 1'b1, 1'b1);
		send_sample(16'hFFFF, 1'b0, 1'b1);
		send_sample(16'h5555, 1'b1, 1'b0);
		send_sample(16'hAAAA, 1'b0, 1'b1);
		send_sample(16'd256, 1'b1, 1'b0);
		send_sample(16'd65280, 1'b0, 1'b1);
	endtask

	// random batches of random length, probabilities biased toward the ends
	task automatic test_random_batches(input int samples);
		logic [15:0] pred;
		int left;
		left = $urandom_range(1, 20);
		for (int i = 0; i < samples; i++) begin
			case ($urandom_range(3))
				0: pred = 16'($urandom_range(0, 300));
				1: pred = 16'($urandom_range(65235, 65535));
				default: pred = 16'($urandom);
			endcase
			left--;
			send_sample(pred, 1'($urandom_range(1)), left == 0);
			if (left == 0)
				left = $urandom_range(1, 20);
		end
		send_sample(16'($urandom), 1'($urandom_range(1)), 1'b1);
	endtask

	// sender holds off until every result is back, then restarts
	task automatic test_drain_pause();
		drain_results();
		send_sample(16'h1234, 1'b1, 1'b0);
		send_sample(16'hEDCB, 1'b0, 1'b1);
	endtask

	// stream with no idling on either side
	task automatic test_back_to_back();
		source_idle_off = 1'b1;
		sink_idle_off = 1'b1;
		test_random_batches(150);
		source_idle_off = 1'b0;
		sink_idle_off = 1'b0;
	endtask

	// check each output transfer against the oldest expectation
	always @(posedge clk) begin
		grad_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", m_axis_tdata);
			end else begin
				exp_r = expected_q.pop_front();
				if (m_axis_tdata[24:0] !== exp_r.gradient
						|| m_axis_tdata[44:25] !== exp_r.mean_loss
						|| m_axis_tuser !== exp_r.loss_valid) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: grad %h/%h mean %h/%h valid %b/%b",
							exp_r.gradient, m_axis_tdata[24:0], exp_r.mean_loss,
							m_axis_tdata[44:25], exp_r.loss_valid, m_axis_tuser);
				end
			end
		end
	end

	// randomly stall the result side
	always @(negedge clk) begin
		m_axis_tready <= sink_idle_off || ($urandom_range(99) >= 27);
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		batch_sum = '0;
		batch_count = '0;
		mismatches = 0;
		sink_idle_off = 1'b0;
		source_idle_off = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_batches(600);
		test_drain_pause();
		test_back_to_back();
		test_random_batches(580);
		drain_results();
		repeat (200) @(negedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#30ms;
		$display("simulation failed");
		$finish;
	end

endmodule

/* binary_cross_entropy_loss_grad.f */
rtl/core/bce_pkg.sv
rtl/core/bce_front.sv
rtl/core/bce_back.sv
rtl/core/binary_cross_entropy_loss_grad.sv
test/binary_cross_entropy_loss_grad_tb.sv
